### src/eq_pkg.sv
// shared types, constants and the cordic arctangent table for euler_to_quaternion
`default_nettype none

package eq_pkg;

    // lanes: one per euler angle
    localparam int NLANE      = 3;
    localparam int LANE_ROLL  = 0;
    localparam int LANE_PITCH = 1;
    localparam int LANE_YAW   = 2;

    // field widths
    localparam int ANGLE_W = 16;
    localparam int OUT_W   = 16;
    localparam int OUT_FRAC = 14;
    localparam int ONE_OUT = 16384;

    // half angle with 30 fraction bits: q3.13 input shifted left by 16
    localparam int ZW          = 34;
    localparam int ANGLE_SHIFT = 16;
    localparam int ZFRAC       = 30;

    // arctangent table length bounds the step count
    localparam int ATAN_LEN = 24;

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic signed [OUT_W-1:0]   quat_t;
    typedef logic signed [ZW-1:0]      zang_t;

    // cordic limit gain in q30
    localparam longint GAIN_Q30 = 64'sd652032874;

    localparam zang_t HALF_PI_Q30 = 34'sd1686629713;
    localparam zang_t PI_Q30      = 34'sd3373259426;

    // atan(2^-i) in q30, truncated
    function automatic zang_t atan_q30(input int idx);
        zang_t val;
        case (idx)
            0:  val = 34'sd843314856;
            1:  val = 34'sd497837829;
            2:  val = 34'sd263043836;
            3:  val = 34'sd133525158;
            4:  val = 34'sd67021686;
            5:  val = 34'sd33543515;
            6:  val = 34'sd16775850;
            7:  val = 34'sd8388437;
            8:  val = 34'sd4194282;
            9:  val = 34'sd2097149;
            10: val = 34'sd1048575;
            11: val = 34'sd524287;
            12: val = 34'sd262143;
            13: val = 34'sd131071;
            14: val = 34'sd65535;
            15: val = 34'sd32767;
            16: val = 34'sd16383;
            17: val = 34'sd8191;
            18: val = 34'sd4095;
            19: val = 34'sd2047;
            20: val = 34'sd1023;
            21: val = 34'sd511;
            22: val = 34'sd255;
            23: val = 34'sd127;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

### src/eq_ifs.sv
// valid/ready channel interfaces for angle items and quaternion items
`default_nettype none

interface eq_angle_if;
    import eq_pkg::*;

    logic   valid;
    logic   ready;
    angle_t roll_angle;
    angle_t pitch_angle;
    angle_t yaw_angle;

    modport source (output valid, output roll_angle, output pitch_angle, output yaw_angle,
                    input ready);
    modport sink   (input valid, input roll_angle, input pitch_angle, input yaw_angle,
                    output ready);
endinterface

interface eq_quat_if;
    import eq_pkg::*;

    logic  valid;
    logic  ready;
    quat_t quat_w;
    quat_t quat_x;
    quat_t quat_y;
    quat_t quat_z;

    modport source (output valid, output quat_w, output quat_x, output quat_y, output quat_z,
                    input ready);
    modport sink   (input valid, input quat_w, input quat_x, input quat_y, input quat_z,
                    output ready);
endinterface

`default_nettype wire

### src/euler_to_quaternion.sv
// top level: zyx euler angles to unit quaternion through a row of cordic cells
// path: the fold register, then min(CORDIC_STEPS, 24) cordic cells, then the
// product stages of eq_combine, from an accepted item to its result item.
// throughput: one item per cycle; every cell and stage takes a new item each
// cycle, and a stall only backs up as far as the first empty stage.
// reset: rst_n clears all valid flags at once; no clearing pass is needed.
`default_nettype none

module euler_to_quaternion #(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 14
) (
    input  wire logic clk,
    input  wire logic rst_n,
    eq_angle_if.sink  angles,
    eq_quat_if.source quat_out
);
    import eq_pkg::*;

    localparam int NSTEP   = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int XW      = FRAC_BITS + 3;
    localparam int GAIN_SH = ZFRAC - FRAC_BITS;
    // gain rounded half up to FRAC_BITS fraction bits
    localparam longint X0  = ((GAIN_Q30 <<< 1) + (64'sd1 <<< GAIN_SH)) >>> (GAIN_SH + 1);

    logic                 valid_c [NSTEP+1];
    logic                 ready_c [NSTEP+1];
    logic signed [XW-1:0] x_c [NSTEP+1][NLANE];
    logic signed [XW-1:0] y_c [NSTEP+1][NLANE];
    zang_t                z_c [NSTEP+1][NLANE];
    logic [NLANE-1:0]     flip_c [NSTEP+1];

    // halving and folding
    eq_fold u_fold (
        .clk      (clk),
        .rst_n    (rst_n),
        .angles   (angles),
        .dn_valid (valid_c[0]),
        .dn_ready (ready_c[0]),
        .z_out    (z_c[0]),
        .flip_out (flip_c[0])
    );

    // start vector of every rotation
    generate
        for (genvar l = 0; l < NLANE; l++)
        begin : g_start
            assign x_c[0][l] = XW'(X0);
            assign y_c[0][l] = '0;
        end
    endgenerate

    // row of cordic cells
    generate
        for (genvar i = 0; i < NSTEP; i++)
        begin : g_cell
            eq_cordic_cell #(
                .XW   (XW),
                .STEP (i)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .up_valid (valid_c[i]),
                .up_ready (ready_c[i]),
                .x_in     (x_c[i]),
                .y_in     (y_c[i]),
                .z_in     (z_c[i]),
                .flip_in  (flip_c[i]),
                .dn_valid (valid_c[i+1]),
                .dn_ready (ready_c[i+1]),
                .x_out    (x_c[i+1]),
                .y_out    (y_c[i+1]),
                .z_out    (z_c[i+1]),
                .flip_out (flip_c[i+1])
            );
        end
    endgenerate

    // products, sums and output register
    eq_combine #(
        .XW        (XW),
        .FRAC_BITS (FRAC_BITS)
    ) u_combine (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (valid_c[NSTEP]),
        .up_ready (ready_c[NSTEP]),
        .x_in     (x_c[NSTEP]),
        .y_in     (y_c[NSTEP]),
        .flip_in  (flip_c[NSTEP]),
        .quat_out (quat_out)
    );

`ifndef SYNTHESIS
    a_out_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        quat_out.valid |->
            (quat_out.quat_w <= ONE_OUT && quat_out.quat_w >= -ONE_OUT &&
             quat_out.quat_x <= ONE_OUT && quat_out.quat_x >= -ONE_OUT &&
             quat_out.quat_y <= ONE_OUT && quat_out.quat_y >= -ONE_OUT &&
             quat_out.quat_z <= ONE_OUT && quat_out.quat_z >= -ONE_OUT))
        else $error("quaternion part outside +-1.0");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !quat_out.valid |-> angles.ready)
        else $error("input stalled while output register is empty");

    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_c[0] |->
            (z_c[0][LANE_ROLL] <= HALF_PI_Q30 && z_c[0][LANE_ROLL] >= -HALF_PI_Q30 &&
             z_c[0][LANE_PITCH] <= HALF_PI_Q30 && z_c[0][LANE_PITCH] >= -HALF_PI_Q30 &&
             z_c[0][LANE_YAW] <= HALF_PI_Q30 && z_c[0][LANE_YAW] >= -HALF_PI_Q30))
        else $error("folded half angle outside +-pi/2");

    // asserting reset is enough to see the flags cleared
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> (!quat_out.valid && !valid_c[0]))
        else $error("valid flags set after a reset cycle");
`endif

endmodule

`default_nettype wire

### src/eq_fold.sv
// input stage: halves each angle and folds it into the cordic range
`default_nettype none

module eq_fold (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    eq_angle_if.sink                      angles,
    output logic                          dn_valid,
    input  wire logic                     dn_ready,
    output eq_pkg::zang_t                 z_out [eq_pkg::NLANE],
    output logic [eq_pkg::NLANE-1:0]      flip_out
);
    import eq_pkg::*;

    logic             valid_reg;
    angle_t           ang [NLANE];
    zang_t            z_half [NLANE];
    zang_t            z_next [NLANE];
    logic [NLANE-1:0] flip_next;
    zang_t            z_reg [NLANE];
    logic [NLANE-1:0] flip_reg;

    assign angles.ready = !valid_reg || dn_ready;

    // fold half angles beyond +-pi/2 by pi and mark the lane for negation
    always_comb
    begin
        ang[LANE_ROLL]  = angles.roll_angle;
        ang[LANE_PITCH] = angles.pitch_angle;
        ang[LANE_YAW]   = angles.yaw_angle;
        for (int l = 0; l < NLANE; l++)
        begin
            z_half[l] = {{(ZW - ANGLE_W - ANGLE_SHIFT){ang[l][ANGLE_W-1]}}, ang[l],
                         {ANGLE_SHIFT{1'b0}}};
            if (z_half[l] > HALF_PI_Q30)
            begin
                z_next[l]    = z_half[l] - PI_Q30;
                flip_next[l] = 1'b1;
            end
            else if (z_half[l] < -HALF_PI_Q30)
            begin
                z_next[l]    = z_half[l] + PI_Q30;
                flip_next[l] = 1'b1;
            end
            else
            begin
                z_next[l]    = z_half[l];
                flip_next[l] = 1'b0;
            end
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (angles.ready)
        begin
            valid_reg <= angles.valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (angles.ready && angles.valid)
        begin
            z_reg    <= z_next;
            flip_reg <= flip_next;
        end
    end

    assign dn_valid = valid_reg;
    assign z_out    = z_reg;
    assign flip_out = flip_reg;

endmodule

`default_nettype wire

### src/eq_cordic_cell.sv
// one cordic rotation step for the three angle lanes, registered
`default_nettype none

module eq_cordic_cell #(
    parameter int XW   = 17,
    parameter int STEP = 0
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         up_valid,
    output logic                              up_ready,
    input  wire logic signed [XW-1:0]         x_in [eq_pkg::NLANE],
    input  wire logic signed [XW-1:0]         y_in [eq_pkg::NLANE],
    input  wire eq_pkg::zang_t                z_in [eq_pkg::NLANE],
    input  wire logic [eq_pkg::NLANE-1:0]     flip_in,
    output logic                              dn_valid,
    input  wire logic                         dn_ready,
    output logic signed [XW-1:0]              x_out [eq_pkg::NLANE],
    output logic signed [XW-1:0]              y_out [eq_pkg::NLANE],
    output eq_pkg::zang_t                     z_out [eq_pkg::NLANE],
    output logic [eq_pkg::NLANE-1:0]          flip_out
);
    import eq_pkg::*;

    localparam zang_t ATAN = atan_q30(STEP);

    logic                 valid_reg;
    logic signed [XW-1:0] x_next [NLANE];
    logic signed [XW-1:0] y_next [NLANE];
    zang_t                z_next [NLANE];
    logic signed [XW-1:0] x_reg [NLANE];
    logic signed [XW-1:0] y_reg [NLANE];
    zang_t                z_reg [NLANE];
    logic [NLANE-1:0]     flip_reg;

    assign up_ready = !valid_reg || dn_ready;

    // rotate toward zero residual angle
    always_comb
    begin
        for (int l = 0; l < NLANE; l++)
        begin
            if (!z_in[l][ZW-1])
            begin
                x_next[l] = x_in[l] - (y_in[l] >>> STEP);
                y_next[l] = y_in[l] + (x_in[l] >>> STEP);
                z_next[l] = z_in[l] - ATAN;
            end
            else
            begin
                x_next[l] = x_in[l] + (y_in[l] >>> STEP);
                y_next[l] = y_in[l] - (x_in[l] >>> STEP);
                z_next[l] = z_in[l] + ATAN;
            end
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            flip_reg <= flip_in;
        end
    end

    assign dn_valid = valid_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign flip_out = flip_reg;

endmodule

`default_nettype wire

### src/eq_combine.sv
// product pipeline: sine/cosine triples to clamped q1.14 quaternion items
`default_nettype none

module eq_combine #(
    parameter int XW        = 17,
    parameter int FRAC_BITS = 14
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         up_valid,
    output logic                              up_ready,
    input  wire logic signed [XW-1:0]         x_in [eq_pkg::NLANE],
    input  wire logic signed [XW-1:0]         y_in [eq_pkg::NLANE],
    input  wire logic [eq_pkg::NLANE-1:0]     flip_in,
    eq_quat_if.source                         quat_out
);
    import eq_pkg::*;

    localparam int NSTAGE = 6;
    localparam int PW     = 2 * XW;
    localparam int SW     = XW + 1;
    localparam int RW     = SW + 5;
    localparam int DSH    = (FRAC_BITS >= OUT_FRAC) ? (FRAC_BITS - OUT_FRAC) : 0;
    localparam int USH    = (FRAC_BITS >= OUT_FRAC) ? 0 : (OUT_FRAC - FRAC_BITS);
    localparam longint HALF_LSB = 64'sd1 <<< (FRAC_BITS - 1);
    localparam longint TWO_DSH  = 64'sd1 <<< DSH;

    // round half up of a product back to FRAC_BITS fraction bits
    function automatic logic signed [XW-1:0] rnd(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = p + PW'(HALF_LSB);
        return XW'(t >>> FRAC_BITS);
    endfunction

    // convert to q1.14 with round half up, then clamp to +-1.0
    function automatic quat_t to_out(input logic signed [SW-1:0] v);
        logic signed [RW-1:0] r;
        if (FRAC_BITS >= OUT_FRAC)
        begin
            r = ((RW'(v) <<< 1) + RW'(TWO_DSH)) >>> (DSH + 1);
        end
        else
        begin
            r = RW'(v) <<< USH;
        end
        if (r > RW'(ONE_OUT))
        begin
            r = RW'(ONE_OUT);
        end
        else if (r < -RW'(ONE_OUT))
        begin
            r = -RW'(ONE_OUT);
        end
        return OUT_W'(r);
    endfunction

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] stage_in_valid;
    logic [NSTAGE-1:0] stage_ready;

    // stage 0: undo fold
    logic signed [XW-1:0] cos_reg [NLANE];
    logic signed [XW-1:0] sin_reg [NLANE];
    // stage 1: roll/pitch products
    logic signed [PW-1:0] p_cc_reg, p_ss_reg, p_sc_reg, p_cs_reg;
    logic signed [XW-1:0] cy1_reg, sy1_reg;
    // stage 2: rounded roll/pitch products
    logic signed [XW-1:0] r_cc_reg, r_ss_reg, r_sc_reg, r_cs_reg;
    logic signed [XW-1:0] cy2_reg, sy2_reg;
    // stage 3: products with yaw terms
    logic signed [PW-1:0] pw1_reg, pw2_reg, px1_reg, px2_reg;
    logic signed [PW-1:0] py1_reg, py2_reg, pz1_reg, pz2_reg;
    // stage 4: sums
    logic signed [SW-1:0] sum_w_reg, sum_x_reg, sum_y_reg, sum_z_reg;
    // stage 5: output register
    quat_t qw_reg, qx_reg, qy_reg, qz_reg;

    // ready ripples back through the stages so bubbles are squeezed out
    always_comb
    begin
        stage_in_valid = {valid_reg[NSTAGE-2:0], up_valid};
        stage_ready[NSTAGE-1] = !valid_reg[NSTAGE-1] || quat_out.ready;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    assign up_ready = stage_ready[0];

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTAGE; k++)
            begin
                if (stage_ready[k])
                begin
                    valid_reg[k] <= stage_in_valid[k];
                end
            end
        end
    end

    // stage 0: negate folded lanes
    always_ff @(posedge clk)
    begin
        if (stage_ready[0] && stage_in_valid[0])
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                cos_reg[l] <= flip_in[l] ? -x_in[l] : x_in[l];
                sin_reg[l] <= flip_in[l] ? -y_in[l] : y_in[l];
            end
        end
    end

    // stage 1: roll times pitch
    always_ff @(posedge clk)
    begin
        if (stage_ready[1] && stage_in_valid[1])
        begin
            p_cc_reg <= PW'(cos_reg[LANE_ROLL]) * PW'(cos_reg[LANE_PITCH]);
            p_ss_reg <= PW'(sin_reg[LANE_ROLL]) * PW'(sin_reg[LANE_PITCH]);
            p_sc_reg <= PW'(sin_reg[LANE_ROLL]) * PW'(cos_reg[LANE_PITCH]);
            p_cs_reg <= PW'(cos_reg[LANE_ROLL]) * PW'(sin_reg[LANE_PITCH]);
            cy1_reg  <= cos_reg[LANE_YAW];
            sy1_reg  <= sin_reg[LANE_YAW];
        end
    end

    // stage 2: round
    always_ff @(posedge clk)
    begin
        if (stage_ready[2] && stage_in_valid[2])
        begin
            r_cc_reg <= rnd(p_cc_reg);
            r_ss_reg <= rnd(p_ss_reg);
            r_sc_reg <= rnd(p_sc_reg);
            r_cs_reg <= rnd(p_cs_reg);
            cy2_reg  <= cy1_reg;
            sy2_reg  <= sy1_reg;
        end
    end

    // stage 3: times yaw
    always_ff @(posedge clk)
    begin
        if (stage_ready[3] && stage_in_valid[3])
        begin
            pw1_reg <= PW'(r_cc_reg) * PW'(cy2_reg);
            pw2_reg <= PW'(r_ss_reg) * PW'(sy2_reg);
            px1_reg <= PW'(r_sc_reg) * PW'(cy2_reg);
            px2_reg <= PW'(r_cs_reg) * PW'(sy2_reg);
            py1_reg <= PW'(r_cs_reg) * PW'(cy2_reg);
            py2_reg <= PW'(r_sc_reg) * PW'(sy2_reg);
            pz1_reg <= PW'(r_cc_reg) * PW'(sy2_reg);
            pz2_reg <= PW'(r_ss_reg) * PW'(cy2_reg);
        end
    end

    // stage 4: round and combine
    always_ff @(posedge clk)
    begin
        if (stage_ready[4] && stage_in_valid[4])
        begin
            sum_w_reg <= SW'(rnd(pw1_reg)) + SW'(rnd(pw2_reg));
            sum_x_reg <= SW'(rnd(px1_reg)) - SW'(rnd(px2_reg));
            sum_y_reg <= SW'(rnd(py1_reg)) + SW'(rnd(py2_reg));
            sum_z_reg <= SW'(rnd(pz1_reg)) - SW'(rnd(pz2_reg));
        end
    end

    // stage 5: output format
    always_ff @(posedge clk)
    begin
        if (stage_ready[5] && stage_in_valid[5])
        begin
            qw_reg <= to_out(sum_w_reg);
            qx_reg <= to_out(sum_x_reg);
            qy_reg <= to_out(sum_y_reg);
            qz_reg <= to_out(sum_z_reg);
        end
    end

    assign quat_out.valid  = valid_reg[NSTAGE-1];
    assign quat_out.quat_w = qw_reg;
    assign quat_out.quat_x = qx_reg;
    assign quat_out.quat_y = qy_reg;
    assign quat_out.quat_z = qz_reg;

endmodule

`default_nettype wire
